// File: src/wsld_pkg.sv
package wsld_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int ADDR_BITS    = 40;

  localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int OCC_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int BLK_W     = 40;
  localparam int TIME_W    = 48;
  localparam int CNT_W     = 48;
  localparam int WIN_W     = 32;
  localparam int SHIFT_W   = 4;
  localparam int ENTRY_W   = ADDR_BITS + TIME_W;
  localparam int PADDR_W   = 3;

  localparam logic REG_WINDOW_TICKS   = 1'b0;
  localparam logic REG_NEIGHBOR_SHIFT = 1'b1;

  localparam logic [WIN_W-1:0]   WINDOW_TICKS_RST   = WIN_W'(512);
  localparam logic [SHIFT_W-1:0] NEIGHBOR_SHIFT_RST = SHIFT_W'(3);

  typedef struct packed {
    logic [WIN_W-1:0]   window_ticks;
    logic [SHIFT_W-1:0] neighbor_shift;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_step;
    logic append;
    logic drop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_read;
    logic occ_zero;
    logic scan_match;
    logic scan_last;
    logic expire;
    logic out_free;
  } stat_t;

endpackage

// File: src/wsld_if.sv
interface wsld_in_if import wsld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BLK_W-1:0]  block_addr;
  logic [TIME_W-1:0] time_tick;

  modport source (output valid, req_type, block_addr, time_tick, input ready);
  modport sink (input valid, req_type, block_addr, time_tick, output ready);
endinterface

interface wsld_out_if import wsld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             neighbor_hit;
  logic             window_overflow;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] block_count;

  modport source (output valid, neighbor_hit, window_overflow, hit_count, block_count,
                  input ready);
  modport sink (input valid, neighbor_hit, window_overflow, hit_count, block_count,
                output ready);
endinterface

// File: src/wsld_ram.sv
module wsld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/wsld_ctrl.sv
module wsld_ctrl import wsld_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_APPEND  = 6'b000100,
    S_EXP_REQ = 6'b001000,
    S_EXP_CHK = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          if (stat.in_read) begin
            state_next = S_FIN;
          end else if (stat.occ_zero) begin
            state_next = S_APPEND;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_match || stat.scan_last) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_EXP_REQ;
      end
      S_EXP_REQ: begin
        state_next = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        if (stat.expire) begin
          cmd.drop   = 1'b1;
          state_next = S_EXP_REQ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/wsld_dp.sv
module wsld_dp import wsld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              in_req_type,
  input  logic [BLK_W-1:0]  in_block_addr,
  input  logic [TIME_W-1:0] in_time_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_neighbor_hit,
  output logic              out_window_overflow,
  output logic [CNT_W-1:0]  out_hit_count,
  output logic [CNT_W-1:0]  out_block_count
);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == '1) ? v : v + CNT_W'(1);
    return r;
  endfunction

  logic                 cur_read;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [TIME_W-1:0]    cur_time;
  logic                 hit;
  logic                 ovf;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     scan_ptr;
  logic [OCC_W-1:0]     scan_idx;
  logic [OCC_W-1:0]     occ;
  logic [CNT_W-1:0]     hit_counter;
  logic [CNT_W-1:0]     block_counter;
  logic [CNT_W-1:0]     hit_counter_next;
  logic [CNT_W-1:0]     block_counter_next;

  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ADDR_BITS-1:0] ent_addr;
  logic [TIME_W-1:0]    ent_time;
  logic [ADDR_BITS:0]   cur_al;
  logic [ADDR_BITS:0]   ent_al;
  logic [TIME_W-1:0]    age;
  logic                 full;

  assign rd_addr  = cmd.scan_step ? scan_ptr : head;
  assign ent_addr = rd_data[ENTRY_W-1:TIME_W];
  assign ent_time = rd_data[TIME_W-1:0];
  assign cur_al   = {1'b0, cur_addr >> cfg.neighbor_shift};
  assign ent_al   = {1'b0, ent_addr >> cfg.neighbor_shift};
  assign age      = cur_time - ent_time;
  assign full     = (occ == OCC_W'(WINDOW_DEPTH));

  wsld_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail),
    .wdata ({cur_addr, cur_time}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign stat.in_read    = in_req_type;
  assign stat.occ_zero   = (occ == '0);
  assign stat.scan_match = (ent_al + (ADDR_BITS+1)'(1) >= cur_al) &&
                           (ent_al <= cur_al + (ADDR_BITS+1)'(1));
  assign stat.scan_last  = (scan_idx == occ - OCC_W'(1));
  assign stat.expire     = (age > {{(TIME_W-WIN_W){1'b0}}, cfg.window_ticks});
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    hit_counter_next   = hit_counter;
    block_counter_next = block_counter;
    if (!cur_read) begin
      block_counter_next = sat_inc(block_counter);
      if (hit) begin
        hit_counter_next = sat_inc(hit_counter);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_read <= in_req_type;
      cur_addr <= ADDR_BITS'(in_block_addr);
      cur_time <= in_time_tick;
    end
    if (cmd.scan_start) begin
      scan_ptr <= wrap_inc(head);
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_ptr <= wrap_inc(scan_ptr);
      scan_idx <= scan_idx + OCC_W'(1);
    end
    if (cmd.latch) begin
      hit <= 1'b0;
    end else if (cmd.scan_step && stat.scan_match) begin
      hit <= 1'b1;
    end
    if (cmd.latch) begin
      ovf <= 1'b0;
    end else if (cmd.append && full) begin
      ovf <= 1'b1;
    end
    if (cmd.finish) begin
      out_neighbor_hit    <= hit && !cur_read;
      out_window_overflow <= ovf && !cur_read;
      out_hit_count       <= hit_counter_next;
      out_block_count     <= block_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      occ           <= '0;
      hit_counter   <= '0;
      block_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.append) begin
        tail <= wrap_inc(tail);
        if (full) begin
          head <= wrap_inc(head);
        end else begin
          occ <= occ + OCC_W'(1);
        end
      end else if (cmd.drop) begin
        head <= wrap_inc(head);
        occ  <= occ - OCC_W'(1);
      end
      if (cmd.finish) begin
        hit_counter   <= hit_counter_next;
        block_counter <= block_counter_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(WINDOW_DEPTH))
    else $error("ring occupancy beyond depth");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_append_occ: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> (occ != '0))
    else $error("ring empty after append");

  a_drop_occ: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (occ > OCC_W'(1)))
    else $error("expiry would drop the newest entry");
`endif

endmodule

// File: src/windowed_spatial_locality_detector.sv
// Windowed spatial locality detector. Each write item is checked against the
// ring of earlier writes (up to WINDOW_DEPTH entries held in one single-port-read
// RAM), so the window is scanned one entry per cycle and the scan stops at the
// first neighbor hit. A write item is scanned, appended to the ring, and then
// the entries at the head older than window_ticks are expired before its result
// is loaded; a read item goes straight to the result. The RAM needs no clearing
// pass after reset: only occupied entries are read. Registers: window_ticks at
// address 0, neighbor_shift at address 4; write them only while the block is idle.
module windowed_spatial_locality_detector import wsld_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  wsld_in_if.sink            in_ch,
  wsld_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks   <= WINDOW_TICKS_RST;
      cfg.neighbor_shift <= NEIGHBOR_SHIFT_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_WINDOW_TICKS:   cfg.window_ticks   <= pwdata;
        REG_NEIGHBOR_SHIFT: cfg.neighbor_shift <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_TICKS:   prdata = cfg.window_ticks;
      REG_NEIGHBOR_SHIFT: prdata = {{(32-SHIFT_W){1'b0}}, cfg.neighbor_shift};
      default:            prdata = '0;
    endcase
  end

  assign in_ch.ready = in_ready;

  wsld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wsld_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_req_type         (in_ch.req_type),
    .in_block_addr       (in_ch.block_addr),
    .in_time_tick        (in_ch.time_tick),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_neighbor_hit    (out_ch.neighbor_hit),
    .out_window_overflow (out_ch.window_overflow),
    .out_hit_count       (out_ch.hit_count),
    .out_block_count     (out_ch.block_count)
  );

endmodule
